FILE: rtl/core/expression_event_dedup_filter_unit_assert.svh
// Assertion macros for the expression event dedup filter.
// Expects signals clk and rst_n in the scope of use.
`ifndef EXPRESSION_EVENT_DEDUP_FILTER_UNIT_ASSERT_SVH
`define EXPRESSION_EVENT_DEDUP_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication
`define EEDF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define EEDF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/eedf_pkg.sv
// Shared constants, types and helpers for the expression event dedup filter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package eedf_pkg;

  // Sizes
  localparam int HISTORY_DEPTH = 16;
  localparam int EVENT_BITS    = 6;
  localparam int IDX_W         = $clog2(HISTORY_DEPTH);
  localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
  localparam int TIME_W        = 32;
  localparam int POWER_W       = 10;
  localparam int EYE_W         = 5;
  localparam int DECAY_W       = 16;
  localparam int CH_W          = 2;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY     = 2'd2;

  // Reset values
  localparam logic [POWER_W-1:0] UPPER_THR_RST = 10'd300;
  localparam logic [POWER_W-1:0] LOWER_THR_RST = 10'd200;
  localparam logic [DECAY_W-1:0] DECAY_RST     = 16'd250;

  // Result channel codes
  localparam logic [CH_W-1:0] CH_LOWER   = 2'd0;
  localparam logic [CH_W-1:0] CH_UPPER   = 2'd1;
  localparam logic [CH_W-1:0] CH_THOUGHT = 2'd2;

  // One stored sample: timestamp and the three raw codes
  typedef struct packed {
    logic [TIME_W-1:0]     stamp;
    logic [EVENT_BITS-1:0] upper;
    logic [EVENT_BITS-1:0] lower;
    logic [EVENT_BITS-1:0] thought;
  } hist_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // word accepted on the input channel
    logic walk;    // issue history reads
    logic append;  // store this sample, build result mask
    logic emit;    // push results to the output register
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic walk_done;
    logic pend_none;
  } ctl_sts_t;

  // Ring index add modulo the depth; both operands below the depth
  function automatic logic [IDX_W-1:0] idx_wrap(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    logic [IDX_W:0] d;
    d = (IDX_W + 1)'(HISTORY_DEPTH);
    s = {1'b0, a} + {1'b0, b};
    if (s >= d) begin
      s = s - d;
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/eedf_ctrl.sv
// Sequencer of the dedup filter: accept, history walk, store, emit.
// Depends on eedf_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module eedf_ctrl
  import eedf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire ctl_sts_t sts,
  output ctl_cmd_t      cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_WALK   = 2'd1;
  localparam logic [1:0] S_APPEND = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_done) begin
          state_nxt = S_APPEND;
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.pend_none) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/eedf_datapath.sv
// Datapath of the dedup filter: config registers, sample registers,
// history ring memory with compaction, result mask and output register.
// Depends on eedf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module eedf_datapath
  import eedf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ctl_cmd_t              cmd,
  output ctl_sts_t                   sts,
  // sample
  input  wire logic [TIME_W-1:0]     in_time_ms,
  input  wire logic [EVENT_BITS-1:0] in_upper_event,
  input  wire logic [POWER_W-1:0]    in_upper_power,
  input  wire logic [EVENT_BITS-1:0] in_lower_event,
  input  wire logic [POWER_W-1:0]    in_lower_power,
  input  wire logic [EVENT_BITS-1:0] in_thought_event,
  input  wire logic [POWER_W-1:0]    in_thought_power,
  input  wire logic [EYE_W-1:0]      in_eye_flags,
  // configuration
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // results
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [CH_W-1:0]            out_channel,
  output logic [EVENT_BITS-1:0]      out_event_code,
  output logic [POWER_W-1:0]         out_event_power,
  output logic [EYE_W-1:0]           out_new_eye_flags,
  output logic [TIME_W-1:0]          out_stamp,
  output logic                       out_last
);

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(HISTORY_DEPTH);

  // Config registers
  logic [POWER_W-1:0] up_thr_r;
  logic [POWER_W-1:0] lo_thr_r;
  logic [DECAY_W-1:0] decay_r;

  // Sample registers
  logic [TIME_W-1:0]     time_r;
  logic [EVENT_BITS-1:0] raw_up_r, raw_lo_r, raw_th_r;
  logic [EVENT_BITS-1:0] cur_up_r, cur_lo_r, cur_th_r;
  logic [EVENT_BITS-1:0] cur_up_nxt, cur_lo_nxt, cur_th_nxt;
  logic [POWER_W-1:0]    pwr_up_r, pwr_lo_r, pwr_th_r;
  logic [POWER_W-1:0]    pwr_up_nxt, pwr_lo_nxt, pwr_th_nxt;
  logic [EYE_W-1:0]      eye_new_r;
  logic [EYE_W-1:0]      prev_eye_r;

  // History ring
  hist_t            mem [HISTORY_DEPTH];
  hist_t            rd_data_r;
  logic             rd_pend_r;
  logic [IDX_W-1:0] head_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] rd_idx_r;
  logic [CNT_W-1:0] kept_r;

  // Result mask: bit0 lower, bit1 upper, bit2 thought
  logic [2:0] pend_r;

  logic out_valid_r;

  // Walk signals
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [TIME_W-1:0] age;
  logic              live;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  hist_t             wr_data;
  logic              full;
  logic [IDX_W-1:0]  app_addr;

  // Emit signals
  logic       out_free;
  logic       emit_fire;
  logic [2:0] pend_clr;

  assign rd_en   = cmd.walk && (rd_idx_r < count_r);
  assign rd_addr = idx_wrap(head_r, rd_idx_r[IDX_W-1:0]);

  // Liveness of the entry read last cycle
  assign age  = time_r - rd_data_r.stamp;
  assign live = rd_pend_r && (age <= {{(TIME_W - DECAY_W){1'b0}}, decay_r});

  // Load thresholds upper/lower; a live code match zeroes the channel
  always_comb begin
    cur_up_nxt = cur_up_r;
    cur_lo_nxt = cur_lo_r;
    cur_th_nxt = cur_th_r;
    pwr_up_nxt = pwr_up_r;
    pwr_lo_nxt = pwr_lo_r;
    pwr_th_nxt = pwr_th_r;
    if (cmd.load) begin
      cur_up_nxt = (in_upper_power < up_thr_r) ? '0 : in_upper_event;
      pwr_up_nxt = (in_upper_power < up_thr_r) ? '0 : in_upper_power;
      cur_lo_nxt = (in_lower_power < lo_thr_r) ? '0 : in_lower_event;
      pwr_lo_nxt = (in_lower_power < lo_thr_r) ? '0 : in_lower_power;
      cur_th_nxt = in_thought_event;
      pwr_th_nxt = in_thought_power;
    end else if (live) begin
      if (rd_data_r.upper == cur_up_r) begin
        cur_up_nxt = '0;
        pwr_up_nxt = '0;
      end
      if (rd_data_r.lower == cur_lo_r) begin
        cur_lo_nxt = '0;
        pwr_lo_nxt = '0;
      end
      if (rd_data_r.thought == cur_th_r) begin
        cur_th_nxt = '0;
        pwr_th_nxt = '0;
      end
    end
  end

  // Live entries are rewritten behind the read pointer; the new sample
  // goes after them, or over the oldest when the ring is full
  assign full     = (kept_r == DEPTH_CNT);
  assign app_addr = full ? head_r : idx_wrap(head_r, kept_r[IDX_W-1:0]);
  assign wr_en    = live || cmd.append;
  assign wr_addr  = cmd.append ? app_addr : idx_wrap(head_r, kept_r[IDX_W-1:0]);
  always_comb begin
    wr_data = rd_data_r;
    if (cmd.append) begin
      wr_data.stamp   = time_r;
      wr_data.upper   = raw_up_r;
      wr_data.lower   = raw_lo_r;
      wr_data.thought = raw_th_r;
    end
  end

  // History memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Sample payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      time_r    <= in_time_ms;
      raw_up_r  <= in_upper_event;
      raw_lo_r  <= in_lower_event;
      raw_th_r  <= in_thought_event;
      eye_new_r <= in_eye_flags & ~prev_eye_r;
    end
    cur_up_r <= cur_up_nxt;
    cur_lo_r <= cur_lo_nxt;
    cur_th_r <= cur_th_nxt;
    pwr_up_r <= pwr_up_nxt;
    pwr_lo_r <= pwr_lo_nxt;
    pwr_th_r <= pwr_th_nxt;
  end

  // Walk counters, ring pointers, eye history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r  <= 1'b0;
      head_r     <= '0;
      count_r    <= '0;
      rd_idx_r   <= '0;
      kept_r     <= '0;
      prev_eye_r <= '0;
    end else begin
      rd_pend_r <= rd_en;
      if (cmd.load) begin
        rd_idx_r   <= '0;
        kept_r     <= '0;
        prev_eye_r <= in_eye_flags;
      end else begin
        if (rd_en) begin
          rd_idx_r <= rd_idx_r + 1'b1;
        end
        if (live) begin
          kept_r <= kept_r + 1'b1;
        end
      end
      if (cmd.append) begin
        if (full) begin
          head_r  <= idx_wrap(head_r, IDX_W'(1));
          count_r <= DEPTH_CNT;
        end else begin
          count_r <= kept_r + 1'b1;
        end
      end
    end
  end

  assign sts.walk_done = (rd_idx_r == count_r) && !rd_pend_r;
  assign sts.pend_none = (pend_r == 3'b000);

  // Config write decode; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_thr_r <= UPPER_THR_RST;
      lo_thr_r <= LOWER_THR_RST;
      decay_r  <= DECAY_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_UPPER_THR: up_thr_r <= cfg_data[POWER_W-1:0];
        REG_LOWER_THR: lo_thr_r <= cfg_data[POWER_W-1:0];
        REG_DECAY:     decay_r  <= cfg_data[DECAY_W-1:0];
        default:       ;
      endcase
    end
  end

  // Lowest pending channel goes first
  assign out_free  = !out_valid_r || !out_stall;
  assign emit_fire = cmd.emit && out_free && (pend_r != 3'b000);
  always_comb begin
    pend_clr = pend_r;
    if (pend_r[0]) begin
      pend_clr[0] = 1'b0;
    end else if (pend_r[1]) begin
      pend_clr[1] = 1'b0;
    end else begin
      pend_clr[2] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.append) begin
        pend_r <= {cur_th_r != '0, cur_up_r != '0,
                   (cur_lo_r != '0) || (eye_new_r != '0)};
      end else if (emit_fire) begin
        pend_r <= pend_clr;
      end
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output word payload
  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_stamp <= time_r;
      out_last  <= (pend_clr == 3'b000);
      if (pend_r[0]) begin
        out_channel       <= CH_LOWER;
        out_event_code    <= cur_lo_r;
        out_event_power   <= pwr_lo_r;
        out_new_eye_flags <= eye_new_r;
      end else if (pend_r[1]) begin
        out_channel       <= CH_UPPER;
        out_event_code    <= cur_up_r;
        out_event_power   <= pwr_up_r;
        out_new_eye_flags <= '0;
      end else begin
        out_channel       <= CH_THOUGHT;
        out_event_code    <= cur_th_r;
        out_event_power   <= pwr_th_r;
        out_new_eye_flags <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: rtl/core/expression_event_dedup_filter_unit.sv
// Top level of the expression event dedup filter: controller plus datapath.
// Depends on eedf_pkg, eedf_ctrl, eedf_datapath and the assertion header.
`timescale 1ns / 1ps
`default_nettype none

// One sample word is taken at a time. After acceptance the block walks the
// live history entries through a single-read-port ring memory, one entry per
// cycle with registered read data, drops expired entries in place, stores
// the new sample, then pushes up to three results (lower, upper, thought)
// through an output register. The history holds at most 16 stored entries,
// and the walk over them sets most of the time from one accept to the next;
// out_stall holding a result delays the next accept further. The next sample
// may be accepted while the final result still waits in the output register.
// History memory needs no clearing pass after reset.

module expression_event_dedup_filter_unit
  import eedf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [TIME_W-1:0]     in_time_ms,
  input  wire logic [EVENT_BITS-1:0] in_upper_event,
  input  wire logic [POWER_W-1:0]    in_upper_power,
  input  wire logic [EVENT_BITS-1:0] in_lower_event,
  input  wire logic [POWER_W-1:0]    in_lower_power,
  input  wire logic [EVENT_BITS-1:0] in_thought_event,
  input  wire logic [POWER_W-1:0]    in_thought_power,
  input  wire logic [EYE_W-1:0]      in_eye_flags,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [CH_W-1:0]            out_channel,
  output logic [EVENT_BITS-1:0]      out_event_code,
  output logic [POWER_W-1:0]         out_event_power,
  output logic [EYE_W-1:0]           out_new_eye_flags,
  output logic [TIME_W-1:0]          out_stamp,
  output logic                       out_last,
  // configuration channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // Registers take a write in any cycle
  assign cfg_ready = 1'b1;

  eedf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  eedf_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_time_ms        (in_time_ms),
    .in_upper_event    (in_upper_event),
    .in_upper_power    (in_upper_power),
    .in_lower_event    (in_lower_event),
    .in_lower_power    (in_lower_power),
    .in_thought_event  (in_thought_event),
    .in_thought_power  (in_thought_power),
    .in_eye_flags      (in_eye_flags),
    .cfg_valid         (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_channel       (out_channel),
    .out_event_code    (out_event_code),
    .out_event_power   (out_event_power),
    .out_new_eye_flags (out_new_eye_flags),
    .out_stamp         (out_stamp),
    .out_last          (out_last)
  );

  // Checks
`include "expression_event_dedup_filter_unit_assert.svh"

  `EEDF_ASSERT_NOW(a_cmd_excl, 1'b1, $onehot0({cmd.load, cmd.walk, cmd.append, cmd.emit}), "controller commands overlap")
  `EEDF_ASSERT_NEXT(a_busy_after_load, cmd.load, in_stall, "input not stalled after accepting a word")
  `EEDF_ASSERT_NOW(a_out_from_emit, $rose(out_valid), $past(cmd.emit), "output word without emit")

endmodule

`default_nettype wire
